>>> sv/lsf_pkg.sv
// Shared constants, types and helpers for the learning switch forwarder.
package lsf_pkg;

  localparam int PORT_COUNT    = 4;
  localparam int TABLE_ENTRIES = 16;
  localparam int ADDRESS_BITS  = 16;

  localparam int IDX_W     = $clog2(TABLE_ENTRIES);
  localparam int PORT_W    = 2;
  localparam int FIELD_W   = 16;
  localparam int TAG_W     = 10;
  localparam int CNT_W     = 16;
  localparam int OUT_PORTS = 4;

  localparam logic [FIELD_W-1:0] BCAST_ADDR = 16'hFFFF;
  localparam logic [CNT_W-1:0]   PEND_MAX   = 16'hFFFF;

  // Request travelling down the cell row.
  typedef struct packed {
    logic                    vld;
    logic                    learn_en;
    logic                    dst_bcast;
    logic                    same_addr;
    logic [PORT_W-1:0]       ingress;
    logic [ADDRESS_BITS-1:0] src;
    logic [ADDRESS_BITS-1:0] dst;
    logic [TAG_W-1:0]        tag;
    logic                    src_hit;
    logic                    moved;
    logic                    free_found;
    logic [IDX_W-1:0]        free_idx;
    logic                    dst_hit;
    logic [PORT_W-1:0]       dst_port;
  } tok_t;

  // Learn write broadcast to all cells.
  typedef struct packed {
    logic                    en;
    logic [IDX_W-1:0]        idx;
    logic [ADDRESS_BITS-1:0] addr;
    logic [PORT_W-1:0]       port;
  } wr_t;

  function automatic logic [ADDRESS_BITS-1:0] to_addr(input logic [FIELD_W-1:0] a);
    logic [ADDRESS_BITS-1:0] r;
    for (int i = 0; i < ADDRESS_BITS; i++) begin
      r[i] = (i < FIELD_W) ? a[i % FIELD_W] : 1'b0;
    end
    return r;
  endfunction

endpackage

>>> sv/lsf_cell.sv
// One address table entry with its stage of the search row.
module lsf_cell import lsf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_index,
  input  tok_t             tok_in,
  input  wr_t              wr,
  output tok_t             tok_out
);

  logic                    valid;
  logic [ADDRESS_BITS-1:0] addr;
  logic [PORT_W-1:0]       port;
  logic [PORT_W-1:0]       port_next;
  tok_t                    tok_next;
  logic                    src_match;

  always_comb begin
    tok_next  = tok_in;
    port_next = port;
    src_match = tok_in.vld && tok_in.learn_en && !tok_in.src_hit && valid &&
                (addr == tok_in.src);
    if (src_match) begin
      tok_next.src_hit = 1'b1;
      if (port != tok_in.ingress) begin
        port_next      = tok_in.ingress;
        tok_next.moved = 1'b1;
      end
    end
    if (tok_in.vld && !valid && !tok_in.free_found) begin
      tok_next.free_found = 1'b1;
      tok_next.free_idx   = cell_index;
    end
    if (tok_in.vld && valid && !tok_in.dst_hit && (addr == tok_in.dst)) begin
      tok_next.dst_hit  = 1'b1;
      tok_next.dst_port = port_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= 1'b0;
      tok_out.vld <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (wr.en && (wr.idx == cell_index)) begin
        valid <= 1'b1;
        addr  <= wr.addr;
        port  <= wr.port;
      end else begin
        port <= port_next;
      end
    end
  end

endmodule

>>> sv/learning_switch_forwarder_core.sv
// Top level of the learning switch forwarder: cell row, learn write-back, counters, output.
// Each request (one frame header) runs down a row of TABLE_ENTRIES cells, one cell per clock,
// learning the source and looking up the destination in the same pass; the learn write,
// forwarding mask and pending counters are settled as it leaves the row. The result then
// passes through the result register and the output register; one request is in flight at
// a time, and the next is taken in the cycle after the previous result has moved into the
// output register. No clearing pass after reset.
module learning_switch_forwarder_core import lsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // ingress_port[1:0], source_address[17:2], destination_address[33:18], frame_tag[43:34]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // forward_mask[3:0], frame_tag_out[13:4], pending_port0[29:14], pending_port1[45:30],
  // pending_port2[61:46], pending_port3[77:62]
  output logic [79:0] m_axis_tdata,
  // destination_found[0], learned_new[1], station_moved[2], learn_dropped[3]
  output logic [3:0]  m_axis_tuser
);

  tok_t tok_chain [TABLE_ENTRIES+1];
  tok_t tok_head;
  tok_t tok_x;
  wr_t  wr;

  logic                  busy;
  logic                  accept;
  logic [FIELD_W-1:0]    src_raw;
  logic [FIELD_W-1:0]    dst_raw;

  logic [CNT_W-1:0]      pend      [PORT_COUNT];
  logic [CNT_W-1:0]      pend_next [PORT_COUNT];
  logic [PORT_COUNT-1:0] mask;
  logic                  learn_new;
  logic                  learn_drop;
  logic                  found;
  logic [PORT_W-1:0]     dport;

  logic                  res_full;
  logic [OUT_PORTS-1:0]  res_mask;
  logic [TAG_W-1:0]      res_tag;
  logic [3:0]            res_flags;
  logic [CNT_W-1:0]      res_pend [OUT_PORTS];
  logic                  out_free;

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && !busy;
  assign src_raw       = s_axis_tdata[17:2];
  assign dst_raw       = s_axis_tdata[33:18];

  always_comb begin
    tok_head            = '0;
    tok_head.vld        = accept;
    tok_head.learn_en   = !((src_raw == BCAST_ADDR) && (ADDRESS_BITS >= FIELD_W));
    tok_head.dst_bcast  = (dst_raw == BCAST_ADDR) && (ADDRESS_BITS >= FIELD_W);
    tok_head.ingress    = s_axis_tdata[1:0];
    tok_head.src        = to_addr(src_raw);
    tok_head.dst        = to_addr(dst_raw);
    tok_head.same_addr  = (to_addr(src_raw) == to_addr(dst_raw));
    tok_head.tag        = s_axis_tdata[43:34];
  end

  assign tok_chain[0] = tok_head;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    lsf_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (IDX_W'(i)),
      .tok_in     (tok_chain[i]),
      .wr         (wr),
      .tok_out    (tok_chain[i+1])
    );
  end

  assign tok_x = tok_chain[TABLE_ENTRIES];

  // Forwarding decision, pending counter update and learn write as the request leaves the row.
  always_comb begin
    learn_new  = tok_x.learn_en && !tok_x.src_hit && tok_x.free_found;
    learn_drop = tok_x.learn_en && !tok_x.src_hit && !tok_x.free_found;
    found      = !tok_x.dst_bcast && (tok_x.dst_hit || (tok_x.same_addr && learn_new));
    dport      = tok_x.dst_hit ? tok_x.dst_port : tok_x.ingress;
    for (int p = 0; p < PORT_COUNT; p++) begin
      if (found) begin
        mask[p] = (int'(dport) == p) && (dport != tok_x.ingress);
      end else begin
        mask[p] = (int'(tok_x.ingress) != p);
      end
    end
    for (int p = 0; p < PORT_COUNT; p++) begin
      pend_next[p] = pend[p];
      if (tok_x.vld && mask[p] && (pend[p] != PEND_MAX)) begin
        pend_next[p] = pend[p] + 1'b1;
      end
    end
    wr.en   = tok_x.vld && learn_new;
    wr.idx  = tok_x.free_idx;
    wr.addr = tok_x.src;
    wr.port = tok_x.ingress;
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      res_full      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      for (int p = 0; p < PORT_COUNT; p++) begin
        pend[p] <= '0;
      end
    end else begin
      for (int p = 0; p < PORT_COUNT; p++) begin
        pend[p] <= pend_next[p];
      end
      if (accept) begin
        busy <= 1'b1;
      end
      if (tok_x.vld) begin
        res_full  <= 1'b1;
        res_tag   <= tok_x.tag;
        res_flags <= {learn_drop, tok_x.moved, learn_new, found};
        for (int q = 0; q < OUT_PORTS; q++) begin
          if (q < PORT_COUNT) begin
            res_mask[q] <= mask[q % PORT_COUNT];
            res_pend[q] <= pend_next[q % PORT_COUNT];
          end else begin
            res_mask[q] <= 1'b0;
            res_pend[q] <= '0;
          end
        end
      end else if (res_full && out_free) begin
        res_full <= 1'b0;
        busy     <= 1'b0;
      end
      if (res_full && out_free) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {2'b00, res_pend[3], res_pend[2], res_pend[1], res_pend[0],
                          res_tag, res_mask};
        m_axis_tuser  <= res_flags;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the learning switch forwarder: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

module tb_top;
  import lsf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [PORT_W-1:0]  ingress;
    logic [FIELD_W-1:0] src;
    logic [FIELD_W-1:0] dst;
    logic [TAG_W-1:0]   tag;
  } frame_t;

  typedef struct packed {
    logic [OUT_PORTS-1:0]            fwd_mask;
    logic [TAG_W-1:0]                tag;
    logic                            dst_found;
    logic                            learned_new;
    logic                            station_moved;
    logic                            learn_dropped;
    logic [OUT_PORTS-1:0][CNT_W-1:0] pending;
  } verdict_t;

  class bridge_scoreboard;
    bit                row_valid [TABLE_ENTRIES];
    bit [FIELD_W-1:0]  row_addr [TABLE_ENTRIES];
    bit [PORT_W-1:0]   row_port [TABLE_ENTRIES];
    bit [CNT_W-1:0]    pending_count [PORT_COUNT];
    verdict_t          awaited_verdicts [$];
    int                faults;

    function int find_station(bit [FIELD_W-1:0] a);
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (row_valid[i] && row_addr[i] == a) return i;
      return -1;
    endfunction

    function int free_row();
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (!row_valid[i]) return i;
      return -1;
    endfunction

    function verdict_t predict_verdict(frame_t f);
      verdict_t v;
      int hit;
      int slot;
      v = '0;
      v.tag = f.tag;
      if (f.src != BCAST_ADDR) begin
        hit = find_station(f.src);
        if (hit < 0) begin
          slot = free_row();
          if (slot < 0) begin
            v.learn_dropped = 1'b1;
          end else begin
            row_valid[slot] = 1'b1;
            row_addr[slot] = f.src;
            row_port[slot] = f.ingress;
            v.learned_new = 1'b1;
          end
        end else if (row_port[hit] != f.ingress) begin
          row_port[hit] = f.ingress;
          v.station_moved = 1'b1;
        end
      end
      hit = (f.dst == BCAST_ADDR) ? -1 : find_station(f.dst);
      if (hit >= 0) begin
        v.dst_found = 1'b1;
        if (row_port[hit] != f.ingress && row_port[hit] < PORT_COUNT)
          v.fwd_mask[row_port[hit]] = 1'b1;
      end else begin
        for (int p = 0; p < PORT_COUNT; p++)
          if (p != f.ingress) v.fwd_mask[p] = 1'b1;
      end
      for (int p = 0; p < PORT_COUNT; p++) begin
        if (v.fwd_mask[p] && pending_count[p] != PEND_MAX)
          pending_count[p] = pending_count[p] + 1'b1;
        v.pending[p] = pending_count[p];
      end
      return v;
    endfunction

    function void note_frame(frame_t f);
      awaited_verdicts.push_back(predict_verdict(f));
    endfunction

    function void check_verdict(logic [79:0] d, logic [3:0] u);
      verdict_t want;
      verdict_t got;
      got.fwd_mask      = d[3:0];
      got.tag           = d[13:4];
      got.pending[0]    = d[29:14];
      got.pending[1]    = d[45:30];
      got.pending[2]    = d[61:46];
      got.pending[3]    = d[77:62];
      got.dst_found     = u[0];
      got.learned_new   = u[1];
      got.station_moved = u[2];
      got.learn_dropped = u[3];
      if (awaited_verdicts.size() == 0) begin
        faults++;
        if (faults <= 10) $display("result with no request outstanding: %h", got);
        return;
      end
      want = awaited_verdicts.pop_front();
      if (got.fwd_mask !== want.fwd_mask || got.tag !== want.tag ||
          got.dst_found !== want.dst_found || got.learned_new !== want.learned_new ||
          got.station_moved !== want.station_moved ||
          got.learn_dropped !== want.learn_dropped ||
          got.pending[0] !== want.pending[0] || got.pending[1] !== want.pending[1] ||
          got.pending[2] !== want.pending[2] || got.pending[3] !== want.pending[3]) begin
        faults++;
        if (faults <= 10) begin
          $display("mismatch tag %h: mask %h/%h found %b/%b new %b/%b moved %b/%b drop %b/%b",
                   want.tag, want.fwd_mask, got.fwd_mask, want.dst_found, got.dst_found,
                   want.learned_new, got.learned_new, want.station_moved, got.station_moved,
                   want.learn_dropped, got.learn_dropped);
          $display("  tag %h/%h pending %h %h %h %h / %h %h %h %h", want.tag, got.tag,
                   want.pending[0], want.pending[1], want.pending[2], want.pending[3],
                   got.pending[0], got.pending[1], got.pending[2], got.pending[3]);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;

  bridge_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count = 0;

  learning_switch_forwarder_core dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("learning_switch_forwarder_core test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_verdict(m_axis_tdata, m_axis_tuser);
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_frame(input logic [PORT_W-1:0] ingress, input logic [FIELD_W-1:0] src,
                            input logic [FIELD_W-1:0] dst, input logic [TAG_W-1:0] tag);
    frame_t f;
    f = '{ingress: ingress, src: src, dst: dst, tag: tag};
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, f.tag, f.dst, f.src, f.ingress};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_frame(f);
  endtask

  // hold the next request back until every result is in
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.awaited_verdicts.size() != 0);
  endtask

  function automatic logic [FIELD_W-1:0] pick_known();
    int rows [$];
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (sb.row_valid[i]) rows.push_back(i);
    if (rows.size() == 0) return FIELD_W'($urandom_range(65535));
    return sb.row_addr[rows[$urandom_range(rows.size() - 1)]];
  endfunction

  task automatic send_random_frame();
    logic [FIELD_W-1:0] src;
    logic [FIELD_W-1:0] dst;
    int r;
    r = $urandom_range(99);
    if (r < 70) src = pick_known();
    else if (r < 85) src = FIELD_W'($urandom_range(65535));
    else if (r < 95) src = BCAST_ADDR;
    else src = pick_known() ^ FIELD_W'(1 << $urandom_range(FIELD_W - 1));
    r = $urandom_range(99);
    if (r < 50) dst = pick_known();
    else if (r < 65) dst = BCAST_ADDR;
    else if (r < 85) dst = FIELD_W'($urandom_range(65535));
    else dst = src;
    send_frame(PORT_W'($urandom_range(3)), src, dst, TAG_W'($urandom_range(1023)));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_frame(2'd0, 16'h0000, BCAST_ADDR, 10'h000);
    send_frame(2'd3, BCAST_ADDR, 16'h0000, 10'h3FF);
    send_frame(2'd1, 16'h0001, 16'h0001, 10'h2AA);
    send_frame(2'd1, 16'h0001, 16'h0000, 10'h155);
    send_frame(2'd2, 16'h0001, 16'h0001, 10'h001);
    send_frame(2'd2, 16'hAAAA, 16'h5555, 10'h200);
    send_frame(2'd1, 16'h5555, 16'hAAAA, 10'h0FF);
    for (int k = 1; k <= 12; k++)
      send_frame(PORT_W'(k % 4), {k[3:0], 8'h5A, k[3:0]}, (k % 2) ? 16'h0001 : 16'hFFFE,
                 TAG_W'(k * 77));
    send_frame(2'd3, 16'hFFFE, BCAST_ADDR, 10'h3C3);
    send_frame(2'd0, 16'h5555, 16'hFFFE, 10'h03C);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 59 : 0;
      recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 19 : 0;
      for (int n = 0; n < 450; n++) begin
        send_random_frame();
        if ($urandom_range(149) == 0) drain_results();
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.faults == 0 && sb.awaited_verdicts.size() == 0) begin
      $display("learning_switch_forwarder_core test passed");
    end else begin
      $display("learning_switch_forwarder_core test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/lsf_pkg.sv
sv/lsf_cell.sv
sv/learning_switch_forwarder_core.sv
bench/tb_top.sv
